/* rtl/apm_pkg.sv */
package apm_pkg;

  // Field and register widths.
  localparam int SCNT_W     = 16;
  localparam int GAIN_W     = 24;
  localparam int SQ_W       = 32;
  localparam int PSUM_W     = 48;
  localparam int RMS_W      = 24;
  localparam int ACT_W      = 32;
  localparam int APP_W      = 32;
  localparam int REACT_W    = 16;
  localparam int PF_W       = 16;
  localparam int GAIN_FRAC  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN = 2'd1;

  // Register reset values: 256 samples, unity gain in Q8.16.
  localparam logic [SCNT_W-1:0] SCNT_RESET = 16'd256;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'h010000;

  // Saturation limits.
  localparam logic [RMS_W-1:0]   RMS_MAX   = '1;
  localparam logic [ACT_W-1:0]   ACT_MAX   = {1'b0, {(ACT_W-1){1'b1}}};
  localparam logic [ACT_W-1:0]   ACT_MIN   = {1'b1, {(ACT_W-1){1'b0}}};
  localparam logic [REACT_W-1:0] REACT_MAX = '1;
  localparam logic [PF_W-1:0]    PF_MAX    = {1'b0, {(PF_W-1){1'b1}}};
  localparam logic [PF_W-1:0]    PF_MIN    = {1'b1, {(PF_W-1){1'b0}}};

  // Data carried alongside the power factor division.
  typedef struct packed {
    logic [RMS_W-1:0] vrms;
    logic [RMS_W-1:0] irms;
    logic [ACT_W-1:0] act;
    logic [APP_W-1:0] app;
    logic             rsat;
    logic [2*REACT_W-1:0] rdiff;
    logic             ovf;
  } pf_side_t;

  // Data carried alongside the reactive power square root.
  typedef struct packed {
    logic [RMS_W-1:0] vrms;
    logic [RMS_W-1:0] irms;
    logic [ACT_W-1:0] act;
    logic [APP_W-1:0] app;
    logic             rsat;
    logic [PF_W-1:0]  pf;
  } rt_side_t;

endpackage

/* rtl/apm_div_cell.sv */
// One restoring division step per cell: shifts in one dividend bit and
// produces one quotient bit. The divisor travels with the beat.
module apm_div_cell #(
  parameter int LANES = 1,
  parameter int DW    = 16,
  parameter int NW    = 16,
  parameter int SW    = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         i_valid,
  input  logic [SW-1:0]                i_side,
  input  logic [NW-1:0]                i_den,
  input  logic [LANES-1:0][NW-1:0]     i_rem,
  input  logic [LANES-1:0][DW-1:0]     i_dq,
  output logic                         o_valid,
  output logic [SW-1:0]                o_side,
  output logic [NW-1:0]                o_den,
  output logic [LANES-1:0][NW-1:0]     o_rem,
  output logic [LANES-1:0][DW-1:0]     o_dq
);

  logic                     valid_r;
  logic [SW-1:0]            side_r;
  logic [NW-1:0]            den_r;
  logic [LANES-1:0][NW-1:0] rem_r, rem_nxt;
  logic [LANES-1:0][DW-1:0] dq_r, dq_nxt;

  // Trial subtract in every lane; the borrow picks the quotient bit.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [NW:0] trial;
    logic [NW:0] diff;
    assign trial      = {i_rem[l], i_dq[l][DW-1]};
    assign diff       = trial - {1'b0, i_den};
    assign rem_nxt[l] = diff[NW] ? trial[NW-1:0] : diff[NW-1:0];
    assign dq_nxt[l]  = {i_dq[l][DW-2:0], ~diff[NW]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= i_side;
    den_r  <= i_den;
    rem_r  <= rem_nxt;
    dq_r   <= dq_nxt;
  end

  assign o_valid = valid_r;
  assign o_side  = side_r;
  assign o_den   = den_r;
  assign o_rem   = rem_r;
  assign o_dq    = dq_r;

endmodule

/* rtl/apm_sqrt_cell.sv */
// One digit-by-digit square root step per cell: takes two radicand bits and
// produces one root bit.
module apm_sqrt_cell #(
  parameter int LANES = 1,
  parameter int RW    = 16,
  parameter int SW    = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          i_valid,
  input  logic [SW-1:0]                 i_side,
  input  logic [LANES-1:0][2*RW-1:0]    i_x,
  input  logic [LANES-1:0][RW+1:0]      i_rem,
  input  logic [LANES-1:0][RW-1:0]      i_root,
  output logic                          o_valid,
  output logic [SW-1:0]                 o_side,
  output logic [LANES-1:0][2*RW-1:0]    o_x,
  output logic [LANES-1:0][RW+1:0]      o_rem,
  output logic [LANES-1:0][RW-1:0]      o_root
);

  logic                        valid_r;
  logic [SW-1:0]               side_r;
  logic [LANES-1:0][2*RW-1:0]  x_r, x_nxt;
  logic [LANES-1:0][RW+1:0]    rem_r, rem_nxt;
  logic [LANES-1:0][RW-1:0]    root_r, root_nxt;

  // Compare the partial remainder against four times the root plus one.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [RW+3:0] cur;
    logic [RW+4:0] diff;
    assign cur         = {i_rem[l], i_x[l][2*RW-1 -: 2]};
    assign diff        = {1'b0, cur} - {3'b000, i_root[l], 2'b01};
    assign rem_nxt[l]  = diff[RW+4] ? cur[RW+1:0] : diff[RW+1:0];
    assign root_nxt[l] = {i_root[l][RW-2:0], ~diff[RW+4]};
    assign x_nxt[l]    = {i_x[l][2*RW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= i_side;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign o_valid = valid_r;
  assign o_side  = side_r;
  assign o_x     = x_r;
  assign o_rem   = rem_r;
  assign o_root  = root_r;

endmodule

/* rtl/ac_power_metrics.sv */
// Pipeline from start to out_valid: 48 mean division cells, 24 RMS root cells,
// three multiply stages, 16 power factor division cells, 16 reactive root
// cells and the output register.
// Throughput: one beat per cycle; busy stays low and results cannot be stalled.
// Reset empties the pipeline and sets sample_count to 256 and current_gain to 1.0.
module ac_power_metrics import apm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [SQ_W-1:0]         in_voltage_sq_sum,
  input  logic [SQ_W-1:0]         in_current_sq_sum,
  input  logic signed [PSUM_W-1:0] in_power_sum,
  output logic                    out_valid,
  output logic [RMS_W-1:0]        out_voltage_rms,
  output logic [RMS_W-1:0]        out_current_rms,
  output logic signed [ACT_W-1:0] out_active_power,
  output logic [APP_W-1:0]        out_apparent_power,
  output logic [REACT_W-1:0]      out_reactive_power,
  output logic signed [PF_W-1:0]  out_power_factor,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int DV_N  = PSUM_W;
  localparam int SQ_N  = RMS_W;
  localparam int PF_N  = PF_W;
  localparam int RT_N  = REACT_W;
  localparam int SQ_SH = 2*RMS_W - SQ_W;

  logic [SCNT_W-1:0] sample_count_r;
  logic [GAIN_W-1:0] current_gain_r;

  // The pipeline takes a beat in every cycle.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= SCNT_RESET;
      current_gain_r <= GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_data[SCNT_W-1:0];
        CFG_CURRENT_GAIN: current_gain_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Mean division chain: lanes are voltage, current and power magnitude.
  logic [DV_N:0]                       dv_valid;
  logic [DV_N:0][0:0]                  dv_side;
  logic [DV_N:0][SCNT_W-1:0]           dv_den;
  logic [DV_N:0][2:0][SCNT_W-1:0]      dv_rem;
  logic [DV_N:0][2:0][PSUM_W-1:0]      dv_dq;
  logic [PSUM_W-1:0]                   psum_mag;

  assign psum_mag     = in_power_sum[PSUM_W-1] ? $unsigned(-in_power_sum)
                                                : $unsigned(in_power_sum);
  assign dv_valid[0]  = start & ~busy;
  assign dv_side[0]   = in_power_sum[PSUM_W-1];
  assign dv_den[0]    = (sample_count_r == '0) ? SCNT_W'(1) : sample_count_r;
  assign dv_rem[0]    = '0;
  assign dv_dq[0][0]  = {{(PSUM_W-SQ_W){1'b0}}, in_voltage_sq_sum};
  assign dv_dq[0][1]  = {{(PSUM_W-SQ_W){1'b0}}, in_current_sq_sum};
  assign dv_dq[0][2]  = psum_mag;

  for (genvar k = 0; k < DV_N; k++) begin : g_dv
    apm_div_cell #(
      .LANES (3),
      .DW    (PSUM_W),
      .NW    (SCNT_W),
      .SW    (1)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (dv_valid[k]),
      .i_side  (dv_side[k]),
      .i_den   (dv_den[k]),
      .i_rem   (dv_rem[k]),
      .i_dq    (dv_dq[k]),
      .o_valid (dv_valid[k+1]),
      .o_side  (dv_side[k+1]),
      .o_den   (dv_den[k+1]),
      .o_rem   (dv_rem[k+1]),
      .o_dq    (dv_dq[k+1])
    );
  end

  // Active power: sign the power quotient and saturate to 32 bits.
  logic [ACT_W-1:0] act1;

  always_comb begin
    logic [PSUM_W-1:0] qp;
    qp = dv_dq[DV_N][2];
    if (dv_side[DV_N][0]) begin
      if ((|qp[PSUM_W-1:ACT_W]) || (qp[ACT_W-1] && (|qp[ACT_W-2:0]))) begin
        act1 = ACT_MIN;
      end else begin
        act1 = ~qp[ACT_W-1:0] + 1'b1;
      end
    end else begin
      act1 = (|qp[PSUM_W-1:ACT_W-1]) ? ACT_MAX : qp[ACT_W-1:0];
    end
  end

  // RMS root chain: lanes are voltage and current.
  logic [SQ_N:0]                       sq_valid;
  logic [SQ_N:0][ACT_W-1:0]            sq_side;
  logic [SQ_N:0][1:0][2*RMS_W-1:0]     sq_x;
  logic [SQ_N:0][1:0][RMS_W+1:0]       sq_rem;
  logic [SQ_N:0][1:0][RMS_W-1:0]       sq_root;

  assign sq_valid[0]  = dv_valid[DV_N];
  assign sq_side[0]   = act1;
  assign sq_x[0][0]   = {dv_dq[DV_N][0][SQ_W-1:0], {SQ_SH{1'b0}}};
  assign sq_x[0][1]   = {dv_dq[DV_N][1][SQ_W-1:0], {SQ_SH{1'b0}}};
  assign sq_rem[0]    = '0;
  assign sq_root[0]   = '0;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    apm_sqrt_cell #(
      .LANES (2),
      .RW    (RMS_W),
      .SW    (ACT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (sq_valid[k]),
      .i_side  (sq_side[k]),
      .i_x     (sq_x[k]),
      .i_rem   (sq_rem[k]),
      .i_root  (sq_root[k]),
      .o_valid (sq_valid[k+1]),
      .o_side  (sq_side[k+1]),
      .o_x     (sq_x[k+1]),
      .o_rem   (sq_rem[k+1]),
      .o_root  (sq_root[k+1])
    );
  end

  // Multiply stage one: current root times gain.
  logic                  m1_valid_r;
  logic [RMS_W-1:0]      m1_vrms_r;
  logic [RMS_W+GAIN_W-1:0] m1_iprod_r;
  logic [ACT_W-1:0]      m1_act_r;

  // Multiply stage two: apparent power product.
  logic                  m2_valid_r;
  logic [RMS_W-1:0]      m2_vrms_r;
  logic [RMS_W-1:0]      m2_irms_r;
  logic [2*RMS_W-1:0]    m2_aprod_r;
  logic [ACT_W-1:0]      m2_act_r;
  logic [RMS_W-1:0]      irms;

  // Multiply stage three: squares for the reactive power.
  logic                  m3_valid_r;
  logic [RMS_W-1:0]      m3_vrms_r;
  logic [RMS_W-1:0]      m3_irms_r;
  logic [APP_W-1:0]      m3_app_r;
  logic [ACT_W-1:0]      m3_act_r;
  logic [ACT_W-1:0]      m3_mag_r;
  logic [2*APP_W-1:0]    m3_a2_r;
  logic [2*ACT_W-1:0]    m3_p2_r;
  logic [APP_W-1:0]      app2;
  logic [ACT_W-1:0]      mag2;

  assign irms = (|m1_iprod_r[RMS_W+GAIN_W-1:RMS_W+GAIN_FRAC]) ? RMS_MAX
              : m1_iprod_r[RMS_W+GAIN_FRAC-1:GAIN_FRAC];
  assign app2 = m2_aprod_r[2*RMS_W-1:2*RMS_W-APP_W];
  assign mag2 = m2_act_r[ACT_W-1] ? (~m2_act_r + 1'b1) : m2_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
      m3_valid_r <= 1'b0;
    end else begin
      m1_valid_r <= sq_valid[SQ_N];
      m2_valid_r <= m1_valid_r;
      m3_valid_r <= m2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_vrms_r  <= sq_root[SQ_N][0];
    m1_iprod_r <= sq_root[SQ_N][1] * current_gain_r;
    m1_act_r   <= sq_side[SQ_N];
    m2_vrms_r  <= m1_vrms_r;
    m2_irms_r  <= irms;
    m2_aprod_r <= m1_vrms_r * irms;
    m2_act_r   <= m1_act_r;
    m3_vrms_r  <= m2_vrms_r;
    m3_irms_r  <= m2_irms_r;
    m3_app_r   <= app2;
    m3_act_r   <= m2_act_r;
    m3_mag_r   <= mag2;
    m3_a2_r    <= app2 * app2;
    m3_p2_r    <= mag2 * mag2;
  end

  // Power factor division: the high part of |act| * 2^15 is preloaded as
  // remainder, so 16 steps suffice unless the quotient overflows.
  logic [PF_N:0]                   pf_valid;
  pf_side_t [PF_N:0]               pf_side;
  logic [PF_N:0][APP_W-1:0]        pf_den;
  logic [PF_N:0][0:0][APP_W-1:0]   pf_rem;
  logic [PF_N:0][0:0][PF_W-1:0]    pf_dq;
  logic [2*APP_W:0]                rdiff_full;

  assign rdiff_full = {1'b0, m3_a2_r} - {1'b0, m3_p2_r};

  assign pf_side[0].vrms  = m3_vrms_r;
  assign pf_side[0].irms  = m3_irms_r;
  assign pf_side[0].act   = m3_act_r;
  assign pf_side[0].app   = m3_app_r;
  assign pf_side[0].rsat  = ~rdiff_full[2*APP_W] & (|rdiff_full[2*APP_W-1:2*REACT_W]);
  assign pf_side[0].rdiff = rdiff_full[2*APP_W] ? '0 : rdiff_full[2*REACT_W-1:0];
  assign pf_side[0].ovf   = {1'b0, m3_mag_r[ACT_W-1:1]} >= m3_app_r;

  assign pf_valid[0]  = m3_valid_r;
  assign pf_den[0]    = m3_app_r;
  assign pf_rem[0][0] = {1'b0, m3_mag_r[ACT_W-1:1]};
  assign pf_dq[0][0]  = {m3_mag_r[0], {(PF_W-1){1'b0}}};

  for (genvar k = 0; k < PF_N; k++) begin : g_pf
    apm_div_cell #(
      .LANES (1),
      .DW    (PF_W),
      .NW    (APP_W),
      .SW    ($bits(pf_side_t))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (pf_valid[k]),
      .i_side  (pf_side[k]),
      .i_den   (pf_den[k]),
      .i_rem   (pf_rem[k]),
      .i_dq    (pf_dq[k]),
      .o_valid (pf_valid[k+1]),
      .o_side  (pf_side[k+1]),
      .o_den   (pf_den[k+1]),
      .o_rem   (pf_rem[k+1]),
      .o_dq    (pf_dq[k+1])
    );
  end

  // Power factor: sign, saturate, and zero when apparent power is zero.
  logic [PF_W-1:0] pf_val;

  always_comb begin
    logic [PF_W-1:0] q;
    pf_side_t        s;
    q = pf_dq[PF_N][0];
    s = pf_side[PF_N];
    if (s.app == '0) begin
      pf_val = '0;
    end else if (s.act[ACT_W-1]) begin
      if (s.ovf || (q[PF_W-1] && (|q[PF_W-2:0]))) begin
        pf_val = PF_MIN;
      end else begin
        pf_val = ~q + 1'b1;
      end
    end else begin
      pf_val = (s.ovf || q[PF_W-1]) ? PF_MAX : q;
    end
  end

  // Reactive power root chain on the low half of the difference of squares.
  logic [RT_N:0]                      rt_valid;
  rt_side_t [RT_N:0]                  rt_side;
  logic [RT_N:0][0:0][2*REACT_W-1:0]  rt_x;
  logic [RT_N:0][0:0][REACT_W+1:0]    rt_rem;
  logic [RT_N:0][0:0][REACT_W-1:0]    rt_root;

  assign rt_side[0].vrms = pf_side[PF_N].vrms;
  assign rt_side[0].irms = pf_side[PF_N].irms;
  assign rt_side[0].act  = pf_side[PF_N].act;
  assign rt_side[0].app  = pf_side[PF_N].app;
  assign rt_side[0].rsat = pf_side[PF_N].rsat;
  assign rt_side[0].pf   = pf_val;

  assign rt_valid[0]  = pf_valid[PF_N];
  assign rt_x[0][0]   = pf_side[PF_N].rdiff;
  assign rt_rem[0]    = '0;
  assign rt_root[0]   = '0;

  for (genvar k = 0; k < RT_N; k++) begin : g_rt
    apm_sqrt_cell #(
      .LANES (1),
      .RW    (REACT_W),
      .SW    ($bits(rt_side_t))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (rt_valid[k]),
      .i_side  (rt_side[k]),
      .i_x     (rt_x[k]),
      .i_rem   (rt_rem[k]),
      .i_root  (rt_root[k]),
      .o_valid (rt_valid[k+1]),
      .o_side  (rt_side[k+1]),
      .o_x     (rt_x[k+1]),
      .o_rem   (rt_rem[k+1]),
      .o_root  (rt_root[k+1])
    );
  end

  // Output register.
  logic                  out_valid_r;
  logic [RMS_W-1:0]      out_vrms_r;
  logic [RMS_W-1:0]      out_irms_r;
  logic [ACT_W-1:0]      out_act_r;
  logic [APP_W-1:0]      out_app_r;
  logic [REACT_W-1:0]    out_react_r;
  logic [PF_W-1:0]       out_pf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rt_valid[RT_N];
    end
  end

  always_ff @(posedge clk) begin
    out_vrms_r  <= rt_side[RT_N].vrms;
    out_irms_r  <= rt_side[RT_N].irms;
    out_act_r   <= rt_side[RT_N].act;
    out_app_r   <= rt_side[RT_N].app;
    out_react_r <= rt_side[RT_N].rsat ? REACT_MAX : rt_root[RT_N][0];
    out_pf_r    <= rt_side[RT_N].pf;
  end

  assign out_valid          = out_valid_r;
  assign out_voltage_rms    = out_vrms_r;
  assign out_current_rms    = out_irms_r;
  assign out_active_power   = $signed(out_act_r);
  assign out_apparent_power = out_app_r;
  assign out_reactive_power = out_react_r;
  assign out_power_factor   = $signed(out_pf_r);

endmodule
